// ===== hdl/rotate_pixel_source_mapper_macros.svh =====
// Assertion macros for the rotate mapper checker.
`ifndef ROTATE_PIXEL_SOURCE_MAPPER_MACROS_SVH
`define ROTATE_PIXEL_SOURCE_MAPPER_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define RPSM_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("rotate mapper check failed");

// Clocked check that also holds during reset.
`define RPSM_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("rotate mapper check failed");

`endif

// ===== hdl/rpsm_pkg.sv =====
// Shared types, codes and sine table builder for the rotate mapper.
`timescale 1ns / 1ps
package rpsm_pkg;

	localparam int CfgIndexW = 2;
	localparam logic [CfgIndexW-1:0] REG_ANGLE  = 2'd0;
	localparam logic [CfgIndexW-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CfgIndexW-1:0] REG_HEIGHT = 2'd2;

	localparam int CoordW = 12;
	localparam int DimW   = 13;
	localparam int AngleW = 16;
	localparam int Quarter = 90;

	typedef enum logic [2:0] {
		ROT_GENERAL = 3'd0,
		ROT_0       = 3'd1,
		ROT_90      = 3'd2,
		ROT_180     = 3'd3,
		ROT_270     = 3'd4
	} rot_kind_t;

	// Shift-and-subtract quotient, used only while building the table.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Sine of k degrees, Taylor series in Q30, rounded to frac fraction bits.
	function automatic logic [31:0] sine_entry(input int k, input int frac);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic [63:0] divisor;
		int shift;
		x = (64'(k) * 64'd19190098069 + 64'd512) >> 10;
		x2 = (x * x) >> 30;
		term = x;
		sum = $signed(x);
		shift = 30 - frac;
		for (int n = 1; n < 20; n++) begin
			if (term != 64'd0) begin
				divisor = 64'(2 * n) * 64'(2 * n + 1);
				term = (term * x2) >> 30;
				term = udiv64(term, divisor);
				if (n % 2 == 1) sum = sum - $signed(term);
				else sum = sum + $signed(term);
			end
		end
		if (sum < 0) sum = 64'sd0;
		return 32'(($unsigned(sum) + (64'd1 << (shift - 1))) >> shift);
	endfunction

endpackage

// ===== hdl/rotate_pixel_source_mapper.sv =====
// Rotate pixel source mapper: seven-stage pipeline from destination to source pixel.
// One item per cycle sustained while the output is not stalled by m_axis_tready.
// Throughput is set by the fully pipelined datapath: two table reads and four
// multipliers per stage set, with a global stall driven by the output register.
// Reset (arst_n low, asynchronous) clears all valid bits and sets the angle
// to 0, width to 640 and height to 480.
`timescale 1ns / 1ps
module rotate_pixel_source_mapper import rpsm_pkg::*; #(
	parameter int MAX_DIM = 4096,
	parameter int TRIG_FRAC_BITS = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,  // dest_x[11:0], dest_y[23:12]
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [23:0]          m_axis_tdata,  // src_x[11:0], src_y[23:12]
	output logic                 m_axis_tuser   // in_range
);

	localparam int F   = TRIG_FRAC_BITS;
	localparam int TW  = F + 2;          // signed sine/cosine
	localparam int XW  = 15;             // signed centered coordinate
	localparam int MW  = TW + XW;        // product
	localparam int PW  = F + 20;         // sum
	localparam int RW  = PW - F - 1;     // rounded coordinate
	localparam logic [16:0] AngleBias = 17'd33120;   // 92 full turns
	localparam logic [15:0] Recip360 = 16'd46603;    // 2^24 / 360

	logic [AngleW-1:0] angle_q;
	logic [DimW-1:0]   width_q, height_q;
	logic [DimW-1:0]   w_cl, h_cl;
	logic signed [XW-1:0] wm1, hm1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q  <= '0;
			width_q  <= 13'd640;
			height_q <= 13'd480;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ANGLE:  angle_q  <= cfg_data;
				REG_WIDTH:  width_q  <= cfg_data[DimW-1:0];
				REG_HEIGHT: height_q <= cfg_data[DimW-1:0];
				default: ;
			endcase
		end
	end

	assign w_cl = (32'(width_q) > MAX_DIM) ? DimW'(MAX_DIM) : width_q;
	assign h_cl = (32'(height_q) > MAX_DIM) ? DimW'(MAX_DIM) : height_q;
	assign wm1 = $signed({2'b00, w_cl}) - XW'(1);
	assign hm1 = $signed({2'b00, h_cl}) - XW'(1);

	// sine table
	logic [F:0] sine_rom [0:Quarter];
	for (genvar k = 0; k <= Quarter; k++) begin : g_rom
		localparam logic [31:0] Entry = sine_entry(k, F);
		assign sine_rom[k] = Entry[F:0];
	end

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	assign en = !v_s7 || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// stage 1: bias angle positive, estimate turns
	logic [16:0] u_in;
	logic [32:0] q_prod;
	logic [16:0] u_s1;
	logic [8:0]  q_s1;
	logic [CoordW-1:0] x_s1, y_s1;
	assign u_in = 17'($signed({angle_q[15], angle_q}) + $signed(AngleBias));
	assign q_prod = 33'(u_in) * 33'(Recip360);

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1 <= u_in;
			q_s1 <= q_prod[32:24];
			x_s1 <= s_axis_tdata[11:0];
			y_s1 <= s_axis_tdata[23:12];
		end
	end

	// stage 2: remainder with one correction, centered coordinates
	logic [16:0] r_raw;
	logic [8:0]  r_s2;
	logic signed [XW-1:0] x2_s2, y2_s2;
	logic [CoordW-1:0] x_s2, y_s2;
	assign r_raw = u_s1 - 17'(q_s1) * 17'd360;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2  <= (r_raw >= 17'd360) ? 9'(r_raw - 17'd360) : r_raw[8:0];
			x2_s2 <= $signed({2'b00, x_s1, 1'b0}) - wm1;
			y2_s2 <= $signed({2'b00, y_s1, 1'b0}) - hm1;
			x_s2  <= x_s1;
			y_s2  <= y_s1;
		end
	end

	// stage 3: quadrant and table offset
	rot_kind_t kind_s3;
	logic [1:0] quad_s3;
	logic [6:0] rem_s3;
	logic signed [XW-1:0] x2_s3, y2_s3;
	logic [CoordW-1:0] x_s3, y_s3;
	logic [1:0] quad_c;
	logic [8:0] base_c;

	always_comb begin
		priority if (r_s2 >= 9'd270) begin
			quad_c = 2'd3; base_c = 9'd270;
		end else if (r_s2 >= 9'd180) begin
			quad_c = 2'd2; base_c = 9'd180;
		end else if (r_s2 >= 9'd90) begin
			quad_c = 2'd1; base_c = 9'd90;
		end else begin
			quad_c = 2'd0; base_c = 9'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s3 <= quad_c;
			rem_s3  <= 7'(r_s2 - base_c);
			if (r_s2 == base_c) begin
				unique case (quad_c)
					2'd0: kind_s3 <= ROT_0;
					2'd1: kind_s3 <= ROT_90;
					2'd2: kind_s3 <= ROT_180;
					2'd3: kind_s3 <= ROT_270;
					default: kind_s3 <= ROT_GENERAL;
				endcase
			end else begin
				kind_s3 <= ROT_GENERAL;
			end
			x2_s3 <= x2_s2;
			y2_s3 <= y2_s2;
			x_s3  <= x_s2;
			y_s3  <= y_s2;
		end
	end

	// stage 4: table lookups and quadrant signs
	logic signed [TW-1:0] sa, sb;
	logic signed [TW-1:0] sin_s4, cos_s4;
	rot_kind_t kind_s4;
	logic signed [XW-1:0] x2_s4, y2_s4;
	logic [CoordW-1:0] x_s4, y_s4;
	assign sa = $signed({1'b0, sine_rom[rem_s3]});
	assign sb = $signed({1'b0, sine_rom[7'(Quarter) - rem_s3]});

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (quad_s3)
				2'd0: begin sin_s4 <= sa;  cos_s4 <= sb;  end
				2'd1: begin sin_s4 <= sb;  cos_s4 <= -sa; end
				2'd2: begin sin_s4 <= -sa; cos_s4 <= -sb; end
				default: begin sin_s4 <= -sb; cos_s4 <= sa; end
			endcase
			kind_s4 <= kind_s3;
			x2_s4 <= x2_s3;
			y2_s4 <= y2_s3;
			x_s4  <= x_s3;
			y_s4  <= y_s3;
		end
	end

	// stage 5: products
	logic signed [MW-1:0] pcx_s5, psy_s5, psx_s5, pcy_s5;
	rot_kind_t kind_s5;
	logic [CoordW-1:0] x_s5, y_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			pcx_s5 <= MW'(cos_s4) * MW'(x2_s4);
			psy_s5 <= MW'(sin_s4) * MW'(y2_s4);
			psx_s5 <= MW'(sin_s4) * MW'(x2_s4);
			pcy_s5 <= MW'(cos_s4) * MW'(y2_s4);
			kind_s5 <= kind_s4;
			x_s5 <= x_s4;
			y_s5 <= y_s4;
		end
	end

	// stage 6: sums and rounding, halves away from zero
	function automatic logic signed [RW-1:0] round_scaled(input logic signed [PW-1:0] n);
		logic [PW-1:0] mag;
		logic [PW-1:0] t;
		mag = n[PW-1] ? PW'(-n) : PW'(n);
		t = (mag + (PW'(1) << F)) >> (F + 1);
		return n[PW-1] ? -$signed(t[RW-1:0]) : $signed(t[RW-1:0]);
	endfunction

	logic signed [PW-1:0] nx, ny;
	logic signed [RW-1:0] gx_s6, gy_s6;
	rot_kind_t kind_s6;
	logic [CoordW-1:0] x_s6, y_s6;
	assign nx = PW'(pcx_s5) + PW'(psy_s5) + (PW'(wm1) <<< F);
	assign ny = PW'(pcy_s5) - PW'(psx_s5) + (PW'(hm1) <<< F);

	always_ff @(posedge clk) begin
		if (en) begin
			gx_s6 <= round_scaled(nx);
			gy_s6 <= round_scaled(ny);
			kind_s6 <= kind_s5;
			x_s6 <= x_s5;
			y_s6 <= y_s5;
		end
	end

	// stage 7: exact mappings, inside test, output register
	logic signed [RW-1:0] xs, ys, xe, ye, wme, hme;
	logic in_img;
	assign xe  = $signed({{(RW-CoordW){1'b0}}, x_s6});
	assign ye  = $signed({{(RW-CoordW){1'b0}}, y_s6});
	assign wme = RW'(wm1);
	assign hme = RW'(hm1);

	always_comb begin
		unique case (kind_s6)
			ROT_0:   begin xs = xe;       ys = ye;       end
			ROT_90:  begin xs = ye;       ys = hme - xe; end
			ROT_180: begin xs = wme - xe; ys = hme - ye; end
			ROT_270: begin xs = wme - ye; ys = xe;       end
			default: begin xs = gx_s6;    ys = gy_s6;    end
		endcase
	end

	assign in_img = !xs[RW-1] && !ys[RW-1]
		&& (xs <= wme) && (ys <= hme);

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= in_img ? {ys[CoordW-1:0], xs[CoordW-1:0]} : '0;
			m_axis_tuser <= in_img;
		end
	end

	assign m_axis_tvalid = v_s7;

endmodule

// ===== hdl/rpsm_checker.sv =====
// Port-level checker for the rotate mapper, bound to the top level.
`timescale 1ns / 1ps
`include "rotate_pixel_source_mapper_macros.svh"
module rpsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_ready,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// a point outside the image reports a zero coordinate pair
	`RPSM_ASSERT(a_outside_zero, clk, arst_n, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 24'd0))
	// a stalled result blocks the input side
	`RPSM_ASSERT(a_stall_blocks, clk, arst_n, (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
	// a stalled result holds
	`RPSM_ASSERT(a_hold, clk, arst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
	// an empty output never stops the input side
	`RPSM_ASSERT(a_ready_free, clk, arst_n, !m_axis_tvalid |-> s_axis_tready)
	// configuration writes are never refused
	`RPSM_ASSERT_ALWAYS(a_cfg_ready, clk, cfg_ready)

endmodule

bind rotate_pixel_source_mapper rpsm_checker u_rpsm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cfg_ready(cfg_ready),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);

// ===== tb/sv/testbench.sv =====
// Testbench for the rotate pixel source mapper: predicts each source coordinate and checks it.
`timescale 1ns / 1ps
module testbench;
	import rpsm_pkg::*;

	typedef struct packed {
		logic [11:0] src_x;
		logic [11:0] src_y;
		logic        in_range;
	} src_pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIndexW-1:0] cfg_index = REG_ANGLE;
	logic [15:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic m_axis_tuser;

	rotate_pixel_source_mapper u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #1 clk = ~clk;

	logic [23:0] pixel_q[$];
	src_pixel_t source_q[$];
	int errors = 0;
	int tx_idle_pct = 15;
	int rx_idle_pct = 50;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_cycles = 0;

	logic [15:0] angle_reg = 16'd0;
	logic [12:0] width_reg = 13'd640;
	logic [12:0] height_reg = 13'd480;
	longint sin_table[0:90];

	function automatic longint sine_q14(input int k);
		logic [63:0] x, x2, term;
		longint sum;
		x = (64'(k) * 64'd19190098069 + 64'd512) >> 10;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int n = 1; n < 20 && term != 0; n++) begin
			term = (term * x2) >> 30;
			term = term / (64'(2 * n) * 64'(2 * n + 1));
			if (n % 2 == 1) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		return longint'((64'(sum) + 64'd32768) >> 16);
	endfunction

	// Divide by 2^15, halves away from zero.
	function automatic longint round_half_pix(input longint n);
		if (n >= 0) return (n + 16384) >>> 15;
		return -((-n + 16384) >>> 15);
	endfunction

	function automatic src_pixel_t map_source(input logic [11:0] dx, input logic [11:0] dy);
		longint x, y, w, h, xs, ys, s, c, sa, sb, x2, y2;
		int a, q, r;
		src_pixel_t res;
		x = longint'(dx);
		y = longint'(dy);
		w = (width_reg > 13'd4096) ? 4096 : longint'(width_reg);
		h = (height_reg > 13'd4096) ? 4096 : longint'(height_reg);
		a = int'($signed(angle_reg)) % 360;
		if (a < 0) a += 360;
		case (a)
			0:   begin xs = x;         ys = y;         end
			90:  begin xs = y;         ys = h - 1 - x; end
			180: begin xs = w - 1 - x; ys = h - 1 - y; end
			270: begin xs = w - 1 - y; ys = x;         end
			default: begin
				q = a / 90;
				r = a % 90;
				sa = sin_table[r];
				sb = sin_table[90 - r];
				case (q)
					0: begin s = sa;  c = sb;  end
					1: begin s = sb;  c = -sa; end
					2: begin s = -sa; c = -sb; end
					default: begin s = -sb; c = sa; end
				endcase
				x2 = 2 * x - (w - 1);
				y2 = 2 * y - (h - 1);
				xs = round_half_pix(c * x2 + s * y2 + (w - 1) * 16384);
				ys = round_half_pix(-s * x2 + c * y2 + (h - 1) * 16384);
			end
		endcase
		if (xs >= 0 && xs < w && ys >= 0 && ys < h) begin
			res.src_x = xs[11:0];
			res.src_y = ys[11:0];
			res.in_range = 1'b1;
		end else begin
			res = '0;
		end
		return res;
	endfunction

	task automatic report(input string what);
		errors++;
		if (errors <= 20) $display("mismatch %0d: %s", errors, what);
	endtask

	// Driver: push the prediction when a transaction completes, then load the next pixel.
	always @(posedge clk) begin : drv
		logic nv;
		logic [23:0] nd;
		nv = s_axis_tvalid;
		nd = s_axis_tdata;
		if (s_axis_tvalid && s_axis_tready) begin
			source_q.push_back(map_source(s_axis_tdata[11:0], s_axis_tdata[23:12]));
			nv = 1'b0;
		end
		if (!nv && pixel_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
			nd = pixel_q.pop_front();
			nv = 1'b1;
		end
		s_axis_tvalid <= nv;
		s_axis_tdata <= nd;
	end

	// Monitor: compare each result against the oldest prediction, then pick the next tready.
	always @(posedge clk) begin : mon
		src_pixel_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (source_q.size() == 0) begin
				report("result with nothing expected");
			end else begin
				want = source_q.pop_front();
				if (m_axis_tdata[11:0] !== want.src_x)
					report($sformatf("src_x got %0d want %0d", m_axis_tdata[11:0], want.src_x));
				if (m_axis_tdata[23:12] !== want.src_y)
					report($sformatf("src_y got %0d want %0d", m_axis_tdata[23:12], want.src_y));
				if (m_axis_tuser !== want.in_range)
					report($sformatf("in_range got %b want %b", m_axis_tuser, want.in_range));
			end
		end
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_cycles = 300;
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic wait_drained();
		wait (pixel_q.size() == 0 && !s_axis_tvalid && source_q.size() == 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CfgIndexW-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_ANGLE:  angle_reg = val;
			REG_WIDTH:  width_reg = val[12:0];
			REG_HEIGHT: height_reg = val[12:0];
			default: ;
		endcase
	endtask

	task automatic setup(input logic [15:0] ang, input logic [15:0] w, input logic [15:0] h);
		wait_drained();
		cfg_write(REG_ANGLE, ang);
		cfg_write(REG_WIDTH, w);
		cfg_write(REG_HEIGHT, h);
	endtask

	function automatic void add_pixel(input int x, input int y);
		pixel_q.push_back({12'(y), 12'(x)});
	endfunction

	function automatic int pick_dim();
		int p;
		p = $urandom_range(99);
		if (p < 70) return $urandom_range(64, 1);
		if (p < 85) return $urandom_range(4096, 1);
		if (p < 92) return 4096;
		if (p < 96) return 1;
		return $urandom_range(8191, 0);
	endfunction

	function automatic logic [15:0] pick_angle();
		int p;
		p = $urandom_range(99);
		if (p < 30) return 16'(90 * $urandom_range(3, 0) + 360 * ($urandom_range(6) - 3));
		return 16'($urandom_range(65535, 0));
	endfunction

	initial begin : stim
		int w, h;
		for (int k = 0; k <= 90; k++) sin_table[k] = sine_q14(k);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings first, then the exact quarter turns and odd angles.
		add_pixel(0, 0); add_pixel(639, 479); add_pixel(4095, 4095); add_pixel(0, 4095);
		add_pixel(320, 240);
		setup(16'd90, 16'd640, 16'd480);
		add_pixel(0, 0); add_pixel(639, 479); add_pixel(500, 100);
		setup(16'd180, 16'd7, 16'd5);
		add_pixel(0, 0); add_pixel(6, 4); add_pixel(10, 2);
		setup(16'd270, 16'd7, 16'd5);
		add_pixel(0, 0); add_pixel(6, 4);
		setup(16'h8000, 16'd4096, 16'd4096);
		add_pixel(0, 0); add_pixel(4095, 4095); add_pixel(2048, 100);
		setup(16'h7fff, 16'd1, 16'd1);
		add_pixel(0, 0); add_pixel(1, 0);
		setup(16'd45, 16'd8191, 16'd5000);
		add_pixel(0, 0); add_pixel(4095, 4095); add_pixel(2000, 1000);
		setup(16'hffff, 16'd0, 16'd0);
		add_pixel(0, 0); add_pixel(3, 3);

		for (int ph = 0; ph < 16; ph++) begin
			w = pick_dim();
			h = pick_dim();
			setup(pick_angle(), 16'(w), 16'(h));
			if (ph == 6) begin tx_idle_pct = 50; rx_idle_pct = 15; end
			if (ph == 11) begin tx_idle_pct = 0; rx_idle_pct = 0; end
			if (ph == 3 || ph == 12) hold_requests++;
			for (int i = 0; i < 125; i++) begin
				if ($urandom_range(99) < 85)
					add_pixel($urandom_range((w > 0 ? w : 1) - 1, 0) % 4096,
						$urandom_range((h > 0 ? h : 1) - 1, 0) % 4096);
				else
					add_pixel($urandom_range(4095, 0), $urandom_range(4095, 0));
				// Pause the sender once until every result is back.
				if (ph == 8 && i == 60) begin
					wait (pixel_q.size() == 0 && !s_axis_tvalid && source_q.size() == 0);
				end
			end
		end

		wait (pixel_q.size() == 0 && !s_axis_tvalid);
		for (int t = 0; t < 5000 && source_q.size() != 0; t++) @(posedge clk);
		if (source_q.size() != 0) report("results still expected at end");
		repeat (20) @(posedge clk);
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
